// ===== sv/wsip_pkg.sv =====
// Shared constants, types and character helpers for the wide string to int64 parser.
package wsip_pkg;

    localparam int unsigned MAX_LEN = 4096;
    localparam int unsigned POS_W   = $clog2(MAX_LEN + 1);

    localparam int unsigned CH_W     = 21;
    localparam int unsigned RADIX_W  = 6;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OFFSET_W = 13;
    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned M_DATA_W = 80;

    // multiply-add unit: 32-bit half word times base plus a small addend
    localparam int unsigned HALF_W = 32;
    localparam int unsigned PROD_W = HALF_W + RADIX_W;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_BAD   = 6'd1;
    localparam logic [RADIX_W-1:0] BASE_AUTO   = 6'd0;
    localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
    localparam logic [RADIX_W-1:0] DIGIT_NONE  = 6'd63;
    localparam logic [RADIX_W-1:0] DIGIT_ALPHA = 6'd10;

    localparam logic [CH_W-1:0] CH_TAB   = 21'd9;
    localparam logic [CH_W-1:0] CH_CR    = 21'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 21'd32;
    localparam logic [CH_W-1:0] CH_PLUS  = 21'd43;
    localparam logic [CH_W-1:0] CH_MINUS = 21'd45;
    localparam logic [CH_W-1:0] CH_0     = 21'd48;
    localparam logic [CH_W-1:0] CH_9     = 21'd57;
    localparam logic [CH_W-1:0] CH_UA    = 21'd65;
    localparam logic [CH_W-1:0] CH_UZ    = 21'd90;
    localparam logic [CH_W-1:0] CH_UX    = 21'd88;
    localparam logic [CH_W-1:0] CH_LA    = 21'd97;
    localparam logic [CH_W-1:0] CH_LZ    = 21'd122;
    localparam logic [CH_W-1:0] CH_LX    = 21'd120;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_DIGIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_BASE = 2'd3;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [HALF_W-1:0]  a;
        logic [RADIX_W-1:0] b;
        logic [RADIX_W-1:0] c;
    } t_mac_req;

    function automatic logic [RADIX_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [RADIX_W-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_0 && c <= CH_9) begin
            d = RADIX_W'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = RADIX_W'(c - CH_LA) + DIGIT_ALPHA;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = RADIX_W'(c - CH_UA) + DIGIT_ALPHA;
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

// ===== sv/wsip_mac.sv =====
// Shared multiply-add unit: 32-bit operand times base plus addend, registered result.
module wsip_mac
    import wsip_pkg::*;
(
    input  logic              i_clk,
    input  t_mac_req          i_req,
    output logic [PROD_W-1:0] o_p
);

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_req.a) * PROD_W'(i_req.b) + PROD_W'(i_req.c);
    end

    assign o_p = r_p;

endmodule

// ===== sv/wide_string_to_int64_parser.sv =====
// A digit that still accumulates passes the decode, high-half and commit states before the
// next transfer can be taken; other characters, and digits after overflow, pass only the decode state.
// The 64-bit multiply-accumulate runs as two passes of one 32x6 multiply-add unit,
// then a limit compare; no new character is taken until that compare has committed.
// The last character then passes the emit state to load the result register; while an earlier
// result is still held there and not taken, the emit state waits, input stalled.
// Reset is synchronous, active low: radix returns to 10, parse state and output valid clear.
// Configuration is always ready and is sampled on the first character of each string.
module wide_string_to_int64_parser
    import wsip_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: radix
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [RADIX_W-1:0]  i_cfg_data,
    // input stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,   // [20:0] ch, [23:21] zero
    input  logic                i_s_axis_tlast,   // last character of the string
    // result stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata    // [63:0] value, [65:64] status,
                                                  // [78:66] end_offset, [79] zero
);

    typedef enum logic [2:0] {
        PH_WS, PH_SIGN, PH_ZERO, PH_PREFIX, PH_DIGITS, PH_DONE, PH_INVALID
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_MHI, S_CMT, S_EMIT
    } t_state;

    t_state              r_state;
    t_phase              r_phase;
    logic [RADIX_W-1:0]  r_radix;
    logic [RADIX_W-1:0]  r_base;
    logic                r_neg;
    logic                r_ovf;
    logic [VALUE_W-1:0]  r_mag;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    r_end_pos;
    logic [CH_W-1:0]     r_ch;
    logic                r_last;
    logic [HALF_W-1:0]   r_lo;
    logic                r_m_tvalid;
    logic [M_DATA_W-1:0] r_m_tdata;

    // decode results
    t_phase              n_phase;
    logic [RADIX_W-1:0]  n_base;
    logic                n_neg;
    logic                w_stamp;
    logic                w_take;
    logic [RADIX_W-1:0]  w_digit;
    logic [POS_W-1:0]    w_pos_inc;

    t_mac_req            w_req;
    logic [PROD_W-1:0]   w_mac_p;

    logic [PROD_W+HALF_W-1:0] w_full;
    logic [PROD_W+HALF_W-1:0] w_limit;

    logic [VALUE_W-1:0]  w_value;
    logic [STATUS_W-1:0] w_status;
    logic [OFFSET_W-1:0] w_offset;
    logic                w_out_free;

    assign w_pos_inc = (r_pos < POS_W'(MAX_LEN)) ? r_pos + 1'b1 : POS_W'(MAX_LEN);
    assign w_digit   = digit_of(r_ch);

    // per-character phase step
    always_comb begin
        logic   first_chr;
        logic   first_dig;
        logic   try_dig;
        t_phase ph;
        first_chr = (r_pos == '0) && (r_phase == PH_WS);
        first_dig = 1'b0;
        try_dig   = 1'b0;
        n_base    = first_chr ? r_radix : r_base;
        ph        = (first_chr && (r_radix == RADIX_BAD || r_radix > RADIX_MAX))
                    ? PH_INVALID : r_phase;
        n_phase   = ph;
        n_neg     = r_neg;
        w_stamp   = 1'b0;
        w_take    = 1'b0;
        unique case (ph)
            PH_WS: begin
                if (is_space(r_ch)) begin
                    n_phase = PH_WS;
                end else if (r_ch == CH_PLUS || r_ch == CH_MINUS) begin
                    n_neg   = (r_ch == CH_MINUS);
                    n_phase = PH_SIGN;
                end else begin
                    first_dig = 1'b1;
                end
            end
            PH_SIGN: first_dig = 1'b1;
            PH_ZERO: begin
                if (r_ch == CH_LX || r_ch == CH_UX) begin
                    n_phase = PH_PREFIX;
                end else begin
                    if (n_base == BASE_AUTO) n_base = BASE_OCT;
                    try_dig = 1'b1;
                end
            end
            PH_PREFIX: begin
                n_base  = BASE_HEX;
                try_dig = 1'b1;
            end
            PH_DIGITS: try_dig = 1'b1;
            default: n_phase = ph;
        endcase
        if (first_dig) begin
            if ((n_base == BASE_AUTO || n_base == BASE_HEX) && r_ch == CH_0) begin
                w_stamp = 1'b1;
                n_phase = PH_ZERO;
            end else begin
                if (n_base == BASE_AUTO) n_base = BASE_DEC;
                try_dig = 1'b1;
            end
        end
        if (try_dig) begin
            if (w_digit < n_base) begin
                w_stamp = 1'b1;
                n_phase = PH_DIGITS;
                w_take  = !r_ovf;
            end else begin
                n_phase = PH_DONE;
            end
        end
    end

    // low half in the decode cycle, high half with the carry of the low half next
    always_comb begin
        if (r_state == S_MHI) begin
            w_req.a = r_mag[VALUE_W-1:HALF_W];
            w_req.b = r_base;
            w_req.c = w_mac_p[PROD_W-1:HALF_W];
        end else begin
            w_req.a = r_mag[HALF_W-1:0];
            w_req.b = n_base;
            w_req.c = w_digit;
        end
    end

    wsip_mac u_mac (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_p   (w_mac_p)
    );

    assign w_full  = {w_mac_p, r_lo};
    assign w_limit = (PROD_W + HALF_W)'(r_neg ? VALUE_MIN : VALUE_MAX);

    always_comb begin
        w_value  = '0;
        w_status = ST_OK;
        w_offset = '0;
        if (r_phase == PH_INVALID) begin
            w_status = ST_BAD_BASE;
        end else if (r_end_pos == '0) begin
            w_status = ST_NO_DIGIT;
        end else if (r_ovf) begin
            w_value  = r_neg ? VALUE_MIN : VALUE_MAX;
            w_status = ST_RANGE;
            w_offset = OFFSET_W'(r_end_pos);
        end else begin
            w_value  = r_neg ? VALUE_W'(0) - r_mag : r_mag;
            w_offset = OFFSET_W'(r_end_pos);
        end
    end

    assign w_out_free = !r_m_tvalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_WS;
            r_radix    <= RADIX_RESET;
            r_base     <= '0;
            r_neg      <= 1'b0;
            r_ovf      <= 1'b0;
            r_mag      <= '0;
            r_pos      <= '0;
            r_end_pos  <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_radix <= i_cfg_data;
            if (r_m_tvalid && i_m_axis_tready && r_state != S_EMIT) r_m_tvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_ch    <= i_s_axis_tdata[CH_W-1:0];
                        r_last  <= i_s_axis_tlast;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_phase <= n_phase;
                    r_base  <= n_base;
                    r_neg   <= n_neg;
                    r_pos   <= w_pos_inc;
                    if (w_stamp) r_end_pos <= w_pos_inc;
                    if (w_take)      r_state <= S_MHI;
                    else if (r_last) r_state <= S_EMIT;
                    else             r_state <= S_IDLE;
                end
                S_MHI: begin
                    r_lo    <= w_mac_p[HALF_W-1:0];
                    r_state <= S_CMT;
                end
                S_CMT: begin
                    if (w_full > w_limit) r_ovf <= 1'b1;
                    else                  r_mag <= w_full[VALUE_W-1:0];
                    r_state <= r_last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    // the result register is free or hands its transfer over this edge
                    if (w_out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= {1'b0, w_offset, w_status, w_value};
                        r_phase    <= PH_WS;
                        r_base     <= '0;
                        r_neg      <= 1'b0;
                        r_ovf      <= 1'b0;
                        r_mag      <= '0;
                        r_pos      <= '0;
                        r_end_pos  <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

endmodule

// ===== sv/wsip_checker.sv =====
// Port-level checks for the wide string to int64 parser, bound to the top level.
module wsip_checker
    import wsip_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [M_DATA_W-1:0] o_m_axis_tdata
);

    logic [VALUE_W-1:0]  w_value;
    logic [STATUS_W-1:0] w_status;
    logic [OFFSET_W-1:0] w_offset;

    assign w_value  = o_m_axis_tdata[VALUE_W-1:0];
    assign w_status = o_m_axis_tdata[VALUE_W+STATUS_W-1:VALUE_W];
    assign w_offset = o_m_axis_tdata[VALUE_W+STATUS_W+OFFSET_W-1:VALUE_W+STATUS_W];

    // a pending result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // a character transfer always leaves the parser busy in the cycle after it
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ready stayed high after a character transfer");

    a_bad_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_status == ST_BAD_BASE || w_status == ST_NO_DIGIT)
        |-> (w_value == '0) && (w_offset == '0))
        else $error("empty result carries value or offset");

    a_range_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_status == ST_RANGE)
        |-> (w_value == VALUE_MAX || w_value == VALUE_MIN) && (w_offset != '0))
        else $error("out-of-range result not saturated");

    a_ok_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_status == ST_OK) |-> (w_offset != '0))
        else $error("good result with zero end offset");

endmodule

bind wide_string_to_int64_parser wsip_checker u_wsip_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
